FILE: design/lsi_pkg.sv
// lsi_pkg: shared types and constants of the lms system identifier
// holds the microcode word layout and the control program rom
// no dependencies
package lsi_pkg;

	localparam int DATA_W    = 16;
	localparam int WEIGHT_W  = 32;
	localparam int CFG_IDX_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_PLANT_GAIN = CFG_IDX_W'(1);

	localparam logic        [DATA_W-1:0] STEP_SIZE_RST  = 16'd655;
	localparam logic signed [DATA_W-1:0] PLANT_GAIN_RST = 16'sd14418;

	typedef enum logic [3:0] {
		S_IDLE, S_REF, S_RDW, S_MAC, S_ACC, S_FIR,
		S_ERR, S_MUE, S_URD, S_UMUL, S_UWR, S_OUT
	} step_t;

	typedef enum logic [1:0] {H_NONE, H_IN, H_OUT} hold_t;
	typedef enum logic [1:0] {B_NEXT, B_MORE, B_ALWAYS} br_t;

	typedef struct packed {
		logic accept;
		logic ref_mul;
		logic rd_w;
		logic mac_mul;
		logic acc_add;
		logic fir;
		logic err;
		logic muerr;
		logic upd_mul;
		logic wr_w;
		logic out_load;
	} ctrl_t;

	typedef struct packed {
		logic more;
		logic out_busy;
	} stat_t;

	typedef struct packed {
		ctrl_t act;
		hold_t hold;
		br_t   br;
		step_t target;
	} ucode_t;

	function automatic ucode_t ucode_rom(step_t s);
		ucode_t w;
		w = '0;
		w.hold = H_NONE;
		w.br = B_NEXT;
		w.target = S_IDLE;
		unique case (s)
			S_IDLE: begin
				w.act.accept = 1'b1;
				w.hold = H_IN;
			end
			S_REF:  w.act.ref_mul = 1'b1;
			S_RDW:  w.act.rd_w = 1'b1;
			S_MAC:  w.act.mac_mul = 1'b1;
			S_ACC: begin
				w.act.acc_add = 1'b1;
				w.br = B_MORE;
				w.target = S_RDW;
			end
			S_FIR:  w.act.fir = 1'b1;
			S_ERR:  w.act.err = 1'b1;
			S_MUE:  w.act.muerr = 1'b1;
			S_URD:  w.act.rd_w = 1'b1;
			S_UMUL: w.act.upd_mul = 1'b1;
			S_UWR: begin
				w.act.wr_w = 1'b1;
				w.br = B_MORE;
				w.target = S_URD;
			end
			S_OUT: begin
				w.act.out_load = 1'b1;
				w.hold = H_OUT;
				w.br = B_ALWAYS;
				w.target = S_IDLE;
			end
			default: w.br = B_ALWAYS;
		endcase
		return w;
	endfunction

endpackage

FILE: design/lsi_if.sv
// lsi_if: valid/ready channel interfaces for samples, results and config writes
// depends on lsi_pkg for field widths
interface lsi_in_if;
	logic                               valid;
	logic                               ready;
	logic signed [lsi_pkg::DATA_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface lsi_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [lsi_pkg::DATA_W-1:0] filter_out;
	logic signed [lsi_pkg::DATA_W-1:0] error_out;

	modport source (output valid, output filter_out, output error_out, input ready);
	modport sink (input valid, input filter_out, input error_out, output ready);
endinterface

interface lsi_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [lsi_pkg::CFG_IDX_W-1:0] index;
	logic [lsi_pkg::DATA_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: design/lms_system_identifier_core.sv
// lms_system_identifier_core: lms adaptive fir identifying a one-tap plant
// one sample word is worked at a time: the next is accepted only after the result word is loaded,
// and the load waits while the previous result word is not yet taken; the microcode loop passes
// the taps twice: each weight is read, multiplied and accumulated, then read, updated and written back
// reset: async active low; taps and weights read as zero, registers at defaults
module lms_system_identifier_core #(
	parameter int NUM_TAPS = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	lsi_in_if.sink      samples,
	lsi_out_if.source   results,
	lsi_cfg_if.sink     cfg
);
	import lsi_pkg::*;

	ctrl_t ctrl;
	stat_t stat;

	assign cfg.ready = 1'b1;

	lsi_useq u_useq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.stat     (stat),
		.in_ready (samples.ready),
		.ctrl     (ctrl)
	);

	lsi_dpath #(
		.NUM_TAPS (NUM_TAPS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.stat       (stat),
		.cfg_we     (cfg.valid && cfg.ready),
		.cfg_idx    (cfg.index),
		.cfg_data   (cfg.data),
		.sample     (samples.sample),
		.res_ready  (results.ready),
		.res_valid  (results.valid),
		.filter_out (results.filter_out),
		.error_out  (results.error_out)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		samples.valid && samples.ready |=> !samples.ready)
		else $error("sample word accepted while previous still in work");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.out_load |-> !stat.out_busy)
		else $error("result register overwritten");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.out_load |=> results.valid)
		else $error("loaded result not presented");

	a_mac_order: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.acc_add |-> $past(ctrl.mac_mul))
		else $error("accumulate without product");

endmodule

FILE: design/lsi_useq.sv
// lsi_useq: microcode sequencer, step counter over the control rom
// depends on lsi_pkg for the rom and control word types
module lsi_useq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  lsi_pkg::stat_t stat,
	output logic           in_ready,
	output lsi_pkg::ctrl_t ctrl
);
	import lsi_pkg::*;

	step_t  pc_q;
	ucode_t word;
	logic   stall;
	logic   taken;

	assign word  = ucode_rom(pc_q);
	assign stall = (word.hold == H_IN && !in_valid) || (word.hold == H_OUT && stat.out_busy);
	assign taken = (word.br == B_ALWAYS) || (word.br == B_MORE && stat.more);
	assign in_ready = word.act.accept;
	assign ctrl = stall ? ctrl_t'('0) : word.act;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_IDLE;
		end else if (!stall) begin
			pc_q <= taken ? word.target : step_t'(pc_q + 4'd1);
		end
	end

endmodule

FILE: design/lsi_dpath.sv
// lsi_dpath: tap line, weight memory, multiplier/accumulator and result register
// depends on lsi_pkg; driven by control words from lsi_useq
module lsi_dpath #(
	parameter int NUM_TAPS = 2
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  lsi_pkg::ctrl_t                     ctrl,
	output lsi_pkg::stat_t                     stat,
	input  logic                               cfg_we,
	input  logic [lsi_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [lsi_pkg::DATA_W-1:0]         cfg_data,
	input  logic signed [lsi_pkg::DATA_W-1:0] sample,
	input  logic                               res_ready,
	output logic                               res_valid,
	output logic signed [lsi_pkg::DATA_W-1:0] filter_out,
	output logic signed [lsi_pkg::DATA_W-1:0] error_out
);
	import lsi_pkg::*;

	localparam int KW    = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;
	localparam int ACC_W = 49 + $clog2(NUM_TAPS);

	logic        [15:0] step_q;
	logic signed [15:0] gain_q;
	logic signed [15:0] tap_q [NUM_TAPS];
	logic signed [15:0] sample_q;
	logic        [KW-1:0] k_q;

	logic signed [31:0] w_mem [NUM_TAPS];
	logic [NUM_TAPS-1:0] w_set_q;
	logic signed [31:0] w_rd_q;
	logic               w_vld_q;
	logic signed [31:0] weff;

	logic signed [16:0]      ref_q;
	logic signed [47:0]      mac_prod_s1;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [15:0]      fir_q;
	logic signed [15:0]      err_q;
	logic signed [32:0]      muerr_q;
	logic signed [48:0]      upd_prod_s1;
	logic                    res_vld_q;

	logic signed [31:0]       ref_prod;
	logic signed [47:0]       mac_prod;
	logic signed [32:0]       mue_prod;
	logic signed [48:0]       upd_prod;
	logic [ACC_W-46:0]        acc_hi;
	logic signed [15:0]       fir_sat;
	logic signed [17:0]       diff;
	logic signed [15:0]       err_sat;
	logic signed [33:0]       upd_sum;
	logic signed [31:0]       upd_sat;
	logic                     rot;

	assign weff = w_vld_q ? w_rd_q : 32'sd0;
	assign rot  = ctrl.mac_mul || ctrl.upd_mul;

	assign ref_prod = sample_q * gain_q;
	assign mac_prod = weff * tap_q[0];
	assign mue_prod = $signed({1'b0, step_q}) * err_q;
	assign upd_prod = muerr_q * tap_q[0];

	assign acc_hi  = acc_q[ACC_W-1:45];
	assign fir_sat = ((&acc_hi) || !(|acc_hi)) ? acc_q[45:30]
		: (acc_q[ACC_W-1] ? 16'sh8000 : 16'sh7fff);

	assign diff    = {ref_q[16], ref_q} - {{2{fir_q[15]}}, fir_q};
	assign err_sat = ((&diff[17:15]) || !(|diff[17:15])) ? diff[15:0]
		: (diff[17] ? 16'sh8000 : 16'sh7fff);

	assign upd_sum = {{2{weff[31]}}, weff} + {upd_prod_s1[48], upd_prod_s1[48:16]};
	assign upd_sat = ((&upd_sum[33:31]) || !(|upd_sum[33:31])) ? upd_sum[31:0]
		: (upd_sum[33] ? 32'sh8000_0000 : 32'sh7fff_ffff);

	assign stat.more     = (k_q != KW'(NUM_TAPS - 1));
	assign stat.out_busy = res_vld_q && !res_ready;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_SIZE_RST;
			gain_q <= PLANT_GAIN_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_STEP_SIZE:  step_q <= cfg_data;
				REG_PLANT_GAIN: gain_q <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// tap line: shift in on accept, rotate one place per pass step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TAPS; i++) begin
				tap_q[i] <= '0;
			end
			k_q <= '0;
		end else begin
			if (ctrl.accept || rot) begin
				for (int i = 0; i < NUM_TAPS - 1; i++) begin
					tap_q[i] <= tap_q[i+1];
				end
				tap_q[NUM_TAPS-1] <= rot ? tap_q[0] : sample;
			end
			if (ctrl.acc_add || ctrl.wr_w) begin
				k_q <= stat.more ? k_q + KW'(1) : '0;
			end
		end
	end

	// weight memory
	always_ff @(posedge clk) begin
		if (ctrl.wr_w) begin
			w_mem[k_q] <= upd_sat;
		end
		if (ctrl.rd_w) begin
			w_rd_q <= w_mem[k_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_set_q <= '0;
			w_vld_q <= 1'b0;
		end else begin
			if (ctrl.wr_w) begin
				w_set_q[k_q] <= 1'b1;
			end
			if (ctrl.rd_w) begin
				w_vld_q <= w_set_q[k_q];
			end
		end
	end

	// arithmetic
	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			sample_q <= sample;
			acc_q <= '0;
		end
		if (ctrl.ref_mul) begin
			ref_q <= ref_prod[31:15];
		end
		if (ctrl.mac_mul) begin
			mac_prod_s1 <= mac_prod;
		end
		if (ctrl.acc_add) begin
			acc_q <= acc_q + {{(ACC_W-48){mac_prod_s1[47]}}, mac_prod_s1};
		end
		if (ctrl.fir) begin
			fir_q <= fir_sat;
		end
		if (ctrl.err) begin
			err_q <= err_sat;
		end
		if (ctrl.muerr) begin
			muerr_q <= mue_prod;
		end
		if (ctrl.upd_mul) begin
			upd_prod_s1 <= upd_prod;
		end
		if (ctrl.out_load) begin
			filter_out <= fir_q;
			error_out <= err_q;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (ctrl.out_load) begin
			res_vld_q <= 1'b1;
		end else if (res_ready) begin
			res_vld_q <= 1'b0;
		end
	end

	assign res_valid = res_vld_q;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for lms_system_identifier_core, random stalls on both channels
// predicts fir output and error per sample word with its own lms model of the taps and weights
// depends on lsi_pkg and the channel interfaces in lsi_if
module tb;
	import lsi_pkg::*;

	localparam int NUM_TAPS    = 2;
	localparam int LATENCY     = 6 * NUM_TAPS + 6;
	localparam int QUIET_LIMIT = 2000;
	localparam int PHASE_ITEMS = 160;

	typedef struct packed {
		logic signed [DATA_W-1:0] fir;
		logic signed [DATA_W-1:0] err;
	} fir_err_t;

	logic clk;
	logic arst_n;

	lsi_in_if  samples_bus ();
	lsi_out_if results_bus ();
	lsi_cfg_if cfg_bus ();

	lms_system_identifier_core #(.NUM_TAPS(NUM_TAPS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(samples_bus),
		.results(results_bus),
		.cfg    (cfg_bus)
	);

	logic signed [DATA_W-1:0]   sample_queue [$];
	fir_err_t                   expected_fir_err [$];
	logic        [DATA_W-1:0]   step_reg;
	logic signed [DATA_W-1:0]   gain_reg;
	logic signed [DATA_W-1:0]   tap_hist [NUM_TAPS];
	logic signed [WEIGHT_W-1:0] coef [NUM_TAPS];

	bit       calm;
	int       error_count = 0;
	int       send_gap;
	int       recv_stall;
	int       quiet_cycles;
	fir_err_t want;

	function automatic longint clamp_signed(longint v, int bits);
		longint lo;
		longint hi;
		lo = -(64'sd1 <<< (bits - 1));
		hi = (64'sd1 <<< (bits - 1)) - 1;
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic void predict_identifier_step(logic signed [DATA_W-1:0] x);
		int       k;
		longint   xs;
		longint   gs;
		longint   mu;
		longint   reference;
		longint   acc;
		longint   fir;
		longint   err;
		longint   mu_err;
		longint   tk;
		longint   wk;
		longint   wnew;
		fir_err_t res;
		for (k = 0; k + 1 < NUM_TAPS; k++)
			tap_hist[k] = tap_hist[k + 1];
		tap_hist[NUM_TAPS - 1] = x;
		xs = x;
		gs = gain_reg;
		mu = step_reg;
		reference = (xs * gs) >>> 15;
		acc = 0;
		for (k = 0; k < NUM_TAPS; k++) begin
			tk = tap_hist[k];
			wk = coef[k];
			acc += wk * tk;
		end
		fir = clamp_signed(acc >>> 30, DATA_W);
		err = clamp_signed(reference - fir, DATA_W);
		mu_err = mu * err;
		for (k = 0; k < NUM_TAPS; k++) begin
			tk = tap_hist[k];
			wk = coef[k];
			wnew = clamp_signed(wk + ((mu_err * tk) >>> 16), WEIGHT_W);
			coef[k] = wnew[WEIGHT_W-1:0];
		end
		res.fir = fir[DATA_W-1:0];
		res.err = err[DATA_W-1:0];
		expected_fir_err.push_back(res);
	endfunction

	function automatic logic signed [DATA_W-1:0] draw_sample();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			case ($urandom_range(0, 4))
				0: return {1'b0, {(DATA_W-1){1'b1}}};
				1: return {1'b1, {(DATA_W-1){1'b0}}};
				2: return '0;
				3: return '1;
				default: return DATA_W'(1);
			endcase
		end
		if (pick < 3)
			return DATA_W'($signed($urandom_range(0, 2047)) - 1024);
		return DATA_W'($urandom);
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
		@(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= value;
		do @(posedge clk); while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
		if (idx == REG_STEP_SIZE)
			step_reg = value;
		else if (idx == REG_PLANT_GAIN)
			gain_reg = value;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (sample_queue.size() != 0 || samples_bus.valid || expected_fir_err.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_unknown_reg();
		write_reg(CFG_IDX_W'($urandom_range(REG_PLANT_GAIN + 1, (1 << CFG_IDX_W) - 1)),
			DATA_W'($urandom));
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// sample word driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samples_bus.valid  <= 1'b0;
			samples_bus.sample <= '0;
			send_gap = 0;
			for (int i = 0; i < NUM_TAPS; i++) begin
				tap_hist[i] = '0;
				coef[i]     = '0;
			end
		end else begin
			if (samples_bus.valid && samples_bus.ready)
				predict_identifier_step(samples_bus.sample);
			if (!samples_bus.valid || samples_bus.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					samples_bus.valid <= 1'b0;
				end else if (sample_queue.size() != 0) begin
					samples_bus.valid  <= 1'b1;
					samples_bus.sample <= sample_queue.pop_front();
					send_gap = calm ? 0 : $urandom_range(0, 18);
				end else begin
					samples_bus.valid <= 1'b0;
				end
			end
		end
	end

	// result word monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results_bus.ready <= 1'b0;
			recv_stall = 0;
		end else begin
			if (results_bus.valid && results_bus.ready) begin
				if (expected_fir_err.size() == 0) begin
					$display("%0t: unexpected result word, expected none, got filter_out %0d error_out %0d",
						$time, results_bus.filter_out, results_bus.error_out);
					error_count++;
				end else begin
					want = expected_fir_err.pop_front();
					if (results_bus.filter_out !== want.fir) begin
						$display("%0t: filter_out expected %0d got %0d",
							$time, want.fir, results_bus.filter_out);
						error_count++;
					end
					if (results_bus.error_out !== want.err) begin
						$display("%0t: error_out expected %0d got %0d",
							$time, want.err, results_bus.error_out);
						error_count++;
					end
				end
				recv_stall = calm ? 0 : $urandom_range(0, 18);
			end
			if (recv_stall > 0) begin
				recv_stall--;
				results_bus.ready <= 1'b0;
			end else begin
				results_bus.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (samples_bus.valid && samples_bus.ready) ||
				(results_bus.valid && results_bus.ready) || (cfg_bus.valid && cfg_bus.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
			$display("tb: done, errors");
			$finish;
		end
	end

	initial begin
		int          phase;
		int          n;
		int          pause_at;
		logic [DATA_W-1:0] step_tab [8];
		logic [DATA_W-1:0] gain_tab [8];

		cfg_bus.valid      = 1'b0;
		cfg_bus.index      = '0;
		cfg_bus.data       = '0;
		step_reg           = STEP_SIZE_RST;
		gain_reg           = PLANT_GAIN_RST;
		calm        = 1'b0;
		arst_n      = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reset defaults, field extremes
		sample_queue = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff, 16'sh0001,
			16'sh7fff, 16'sh7fff};
		wait_drained();

		// full scale reference, ignored register indexes
		write_reg(REG_PLANT_GAIN, 16'h8000);
		write_reg(CFG_IDX_W'(REG_PLANT_GAIN + 1), 16'h5a5a);
		write_reg('1, 16'ha5a5);
		sample_queue = '{16'sh8000, 16'sh8000, 16'sh7fff};
		wait_drained();

		// maximum step on full scale alternating input drives the weights into saturation
		write_reg(REG_STEP_SIZE, 16'hffff);
		write_reg(REG_PLANT_GAIN, 16'h7fff);
		for (n = 0; n < 12; n++)
			sample_queue.push_back(n[0] ? 16'sh8000 : 16'sh7fff);
		wait_drained();

		step_tab = '{16'd0, 16'hffff, STEP_SIZE_RST, 16'd1, 16'h8000,
			DATA_W'($urandom), 16'd4096, DATA_W'($urandom)};
		gain_tab = '{16'h8000, 16'h7fff, PLANT_GAIN_RST, 16'h0000, DATA_W'($urandom),
			16'hc000, DATA_W'($urandom), 16'h8000};

		for (phase = 0; phase < 8; phase++) begin
			calm = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 1)) begin
				write_reg(REG_STEP_SIZE, step_tab[phase]);
				write_reg(REG_PLANT_GAIN, gain_tab[phase]);
			end else begin
				write_reg(REG_PLANT_GAIN, gain_tab[phase]);
				write_reg(REG_STEP_SIZE, step_tab[phase]);
			end
			if ($urandom_range(0, 1))
				write_unknown_reg();
			pause_at = $urandom_range(20, PHASE_ITEMS - 20);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (n == pause_at)
					wait_drained();
				sample_queue.push_back(draw_sample());
			end
			wait_drained();
		end

		repeat (4 * LATENCY) @(posedge clk);
		if (error_count == 0 && expected_fir_err.size() == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

FILE: lms_system_identifier_core.f
design/lsi_pkg.sv
design/lsi_if.sv
design/lsi_useq.sv
design/lsi_dpath.sv
design/lms_system_identifier_core.sv
tb/tb.sv
